/* design/swsfd_pkg.sv */
// ----------------------------------------------------------------------------
// swsfd_pkg: shared types and constants of the single-wire sensor frame decoder
// Item payloads, phase codes, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package swsfd_pkg;

  // Counted bits in one frame.
  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned NUM_BYTES  = 5;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 8;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RESP = 3'd1,
    PH_DATA = 3'd2,
    PH_RECV = 3'd3,
    PH_DONE = 3'd4,
    PH_ERR  = 3'd5
  } phase_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_EDGE  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_BELOW = 8'd0,
    REG_ZERO_BELOW  = 8'd1,
    REG_ONE_ABOVE   = 8'd2,
    REG_SKIP_ABOVE  = 8'd3
  } cfg_reg_e;

  localparam logic [7:0] ERROR_BELOW_RST = 8'd40;
  localparam logic [7:0] ZERO_BELOW_RST  = 8'd70;
  localparam logic [7:0] ONE_ABOVE_RST   = 8'd120;
  localparam logic [7:0] SKIP_ABOVE_RST  = 8'd160;
  localparam logic [7:0] NOT_READY_BYTE  = 8'd255;

  // Byte order of the frame.
  localparam int unsigned B_HUM_INT  = 0;
  localparam int unsigned B_HUM_FRAC = 1;
  localparam int unsigned B_TMP_INT  = 2;
  localparam int unsigned B_TMP_FRAC = 3;
  localparam int unsigned B_CHECK    = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] high_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] humidity;
    logic [7:0] temperature;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_frac;
    logic [7:0] check_byte;
    logic [7:0] check_diff;
  } out_item_t;

endpackage

/* design/single_wire_sensor_frame_decoder.sv */
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_decoder
// Decodes the pulse widths of a single-wire humidity/temperature sensor frame.
// ----------------------------------------------------------------------------
// Each input item is a start command or a falling edge with the preceding high
// pulse width in ticks; every item yields one result with the phase, the five
// frame bytes and the checksum difference. An item is decoded by the logic
// between the phase/byte registers and the result register, so one item is
// taken per clock unless the input stalls; the result is registered. A
// two-entry output stage (result register plus skid register) keeps the input
// open while one result waits; the input stalls only when both are full.
// Configuration writes are always ready and take effect at once.
module single_wire_sensor_frame_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  swsfd_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output swsfd_pkg::out_item_t                 out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swsfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                           cfg_data_i
);

  logic [7:0] error_below_q, zero_below_q, one_above_q, skip_above_q;

  swsfd_pkg::phase_e             phase_q, phase_d;
  logic [swsfd_pkg::CNT_W-1:0]   bit_count_q, bit_count_d;
  logic [7:0]                    data_q [swsfd_pkg::NUM_BYTES];
  logic [7:0]                    data_d [swsfd_pkg::NUM_BYTES];

  swsfd_pkg::out_item_t out_q, skid_q, result;
  logic                 out_valid_q, skid_valid_q;
  logic                 accept, cfg_write, shift_en;
  logic                 is_zero, is_one;
  logic [2:0]           byte_idx;
  logic [7:0]           sum4;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_below_q <= swsfd_pkg::ERROR_BELOW_RST;
      zero_below_q  <= swsfd_pkg::ZERO_BELOW_RST;
      one_above_q   <= swsfd_pkg::ONE_ABOVE_RST;
      skip_above_q  <= swsfd_pkg::SKIP_ABOVE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        swsfd_pkg::REG_ERROR_BELOW: error_below_q <= cfg_data_i;
        swsfd_pkg::REG_ZERO_BELOW:  zero_below_q  <= cfg_data_i;
        swsfd_pkg::REG_ONE_ABOVE:   one_above_q   <= cfg_data_i;
        swsfd_pkg::REG_SKIP_ABOVE:  skip_above_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_zero  = in_item_i.high_ticks < zero_below_q;
  assign is_one   = in_item_i.high_ticks > one_above_q;
  assign byte_idx = bit_count_q[swsfd_pkg::CNT_W-1:3];

  // Next phase, bit count and frame bytes for the item at the input.
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_en    = 1'b0;
    if (in_item_i.func == swsfd_pkg::FUNC_START) begin
      phase_d = swsfd_pkg::PH_RESP;
    end else begin
      unique case (phase_q)
        swsfd_pkg::PH_RESP: begin
          if (in_item_i.high_ticks > skip_above_q) begin
            phase_d     = swsfd_pkg::PH_RECV;
            bit_count_d = '0;
          end else begin
            phase_d = swsfd_pkg::PH_DATA;
          end
        end
        swsfd_pkg::PH_DATA: begin
          phase_d     = swsfd_pkg::PH_RECV;
          bit_count_d = '0;
        end
        swsfd_pkg::PH_RECV: begin
          if (in_item_i.high_ticks < error_below_q) begin
            phase_d = swsfd_pkg::PH_ERR;
          end else begin
            shift_en = 1'b1;
            if (bit_count_q >= swsfd_pkg::CNT_W'(swsfd_pkg::FRAME_BITS - 1)) begin
              phase_d = swsfd_pkg::PH_DONE;
            end
            bit_count_d = bit_count_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A width can be both below zero_below and above one_above: shift 0 then 1.
  always_comb begin
    for (int i = 0; i < swsfd_pkg::NUM_BYTES; i++) begin
      data_d[i] = data_q[i];
      if (shift_en && byte_idx == 3'(i)) begin
        if (is_zero && is_one) begin
          data_d[i] = {data_q[i][5:0], 2'b01};
        end else if (is_zero) begin
          data_d[i] = {data_q[i][6:0], 1'b0};
        end else if (is_one) begin
          data_d[i] = {data_q[i][6:0], 1'b1};
        end
      end
    end
  end

  assign sum4 = data_d[swsfd_pkg::B_HUM_INT] + data_d[swsfd_pkg::B_HUM_FRAC]
              + data_d[swsfd_pkg::B_TMP_INT] + data_d[swsfd_pkg::B_TMP_FRAC];

  always_comb begin
    result.status           = phase_d;
    result.humidity         = (phase_d == swsfd_pkg::PH_DONE) ?
                              data_d[swsfd_pkg::B_HUM_INT] : swsfd_pkg::NOT_READY_BYTE;
    result.temperature      = (phase_d == swsfd_pkg::PH_DONE) ?
                              data_d[swsfd_pkg::B_TMP_INT] : swsfd_pkg::NOT_READY_BYTE;
    result.humidity_frac    = data_d[swsfd_pkg::B_HUM_FRAC];
    result.temperature_frac = data_d[swsfd_pkg::B_TMP_FRAC];
    result.check_byte       = data_d[swsfd_pkg::B_CHECK];
    result.check_diff       = sum4 - data_d[swsfd_pkg::B_CHECK];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= swsfd_pkg::PH_IDLE;
      bit_count_q <= '0;
      for (int i = 0; i < swsfd_pkg::NUM_BYTES; i++) begin
        data_q[i] <= '0;
      end
    end else if (accept) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      for (int i = 0; i < swsfd_pkg::NUM_BYTES; i++) begin
        data_q[i] <= data_d[i];
      end
    end
  end

  // Output stage: park the new item in the skid register while the result
  // register is held; drain the skid register first once the output moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_q <= result;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= result;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid item held without a result in the output register");

  a_start_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.func == swsfd_pkg::FUNC_START |=> phase_q == swsfd_pkg::PH_RESP)
    else $error("start item did not enter the response phase");

  a_recv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == swsfd_pkg::PH_RECV |->
      bit_count_q < swsfd_pkg::CNT_W'(swsfd_pkg::FRAME_BITS))
    else $error("bit count ran past the frame while receiving");

  a_not_done_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != 3'(swsfd_pkg::PH_DONE) |->
      out_q.humidity == swsfd_pkg::NOT_READY_BYTE &&
      out_q.temperature == swsfd_pkg::NOT_READY_BYTE)
    else $error("readings shown before the frame is done");
`endif

endmodule
